// ===== hw/rtl/lzwd_pkg.sv =====
// Package for the keyed 12-bit LZW decoder: shared types, constants and codes.
// Used by the top, front, queue and back modules; depends on nothing.
package lzwd_pkg;

    localparam int DictEntriesDefault = 4096;
    localparam int MaxStringDefault   = 31;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY0    = 3'd0;
    localparam logic [2:0] CFG_KEY1    = 3'd1;
    localparam logic [2:0] CFG_KEY2    = 3'd2;
    localparam logic [2:0] CFG_KEY3    = 3'd3;
    localparam logic [2:0] CFG_KEY_LEN = 3'd4;

    // Code word handed from the front part to the back part.
    typedef struct packed {
        logic signed [13:0] code;
    } code_item_t;

endpackage

// ===== hw/rtl/lzw_decoder_12bit_keyed_top.sv =====
// Top level of the keyed 12-bit LZW decoder: front, queue and back parts.
// Depends on lzwd_pkg, lzwd_front, lzwd_queue and lzwd_back.
// The back part handles one code at a time: a registered length lookup, a chain walk
// with a registered read per step, the output bytes and the table write; it takes no
// new code until the previous one is done. Reset: async, active low.
module lzw_decoder_12bit_keyed_top #(
    parameter int DICT_ENTRIES = lzwd_pkg::DictEntriesDefault,
    parameter int MAX_STRING   = lzwd_pkg::MaxStringDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_code,
    output logic [1:0]  status
);
    import lzwd_pkg::*;

    logic       f_valid;
    logic       f_stall;
    code_item_t f_item;
    logic       b_valid;
    logic       b_stall;
    code_item_t b_item;

    lzwd_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .in_byte(in_byte), .q_valid(f_valid), .q_stall(f_stall), .q_item(f_item));

    lzwd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_stall(f_stall),
        .wr_item(f_item), .rd_valid(b_valid), .rd_stall(b_stall), .rd_item(b_item));

    lzwd_back #(.DICT_ENTRIES(DICT_ENTRIES), .MAX_STRING(MAX_STRING)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(b_valid), .q_stall(b_stall),
        .q_item(b_item), .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .last_of_code(last_of_code), .status(status));

endmodule

// ===== hw/rtl/lzwd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/lzwd_front.sv =====
// Front part: unpacks bytes into 12-bit codes and subtracts the key byte.
// Depends on lzwd_pkg.
module lzwd_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             in_byte,
    output logic                   q_valid,
    input  logic                   q_stall,
    output lzwd_pkg::code_item_t   q_item
);
    import lzwd_pkg::*;

    logic [63:0]  key_reg [4];
    logic [5:0]   key_len_reg;
    logic [1:0]   phase_reg;
    logic [7:0]   held_reg;
    logic [4:0]   key_pos_reg;
    logic         q_valid_reg;
    code_item_t   q_item_reg;

    logic         accept;
    logic [5:0]   eff_len;
    logic [7:0]   key_byte;
    logic [11:0]  raw_code;
    logic [5:0]   pos_inc;

    assign in_stall = q_valid_reg && q_stall;
    assign accept   = in_valid && !in_stall;
    assign q_valid  = q_valid_reg;
    assign q_item   = q_item_reg;

    // Effective key length, clamped to 1..32.
    always_comb
    begin
        if (key_len_reg == 6'd0)
        begin
            eff_len = 6'd1;
        end
        else if (key_len_reg > 6'd32)
        begin
            eff_len = 6'd32;
        end
        else
        begin
            eff_len = key_len_reg;
        end
    end

    // Current key byte and unpacked code.
    assign key_byte = key_reg[key_pos_reg[4:3]][{key_pos_reg[2:0], 3'b000} +: 8];
    assign raw_code = (phase_reg == 2'd1) ? {held_reg, in_byte[7:4]}
                                          : {held_reg[3:0], in_byte};
    assign pos_inc  = {1'b0, key_pos_reg} + 6'd1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0]  <= '0;
            key_reg[1]  <= '0;
            key_reg[2]  <= '0;
            key_reg[3]  <= '0;
            key_len_reg <= 6'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY0:    key_reg[0]  <= cfg_data;
                CFG_KEY1:    key_reg[1]  <= cfg_data;
                CFG_KEY2:    key_reg[2]  <= cfg_data;
                CFG_KEY3:    key_reg[3]  <= cfg_data;
                CFG_KEY_LEN: key_len_reg <= cfg_data[5:0];
                default:     ;
            endcase
        end
    end

    // Unpacking state and the output register toward the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 2'd0;
            held_reg    <= '0;
            key_pos_reg <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && (phase_reg == 2'd1 || phase_reg == 2'd2))
            begin
                q_valid_reg <= 1'b1;
            end
            else if (!q_stall)
            begin
                q_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                if (phase_reg == 2'd1 || phase_reg == 2'd2)
                begin
                    key_pos_reg <= (pos_inc >= eff_len) ? 5'd0 : pos_inc[4:0];
                    phase_reg   <= (phase_reg == 2'd1) ? 2'd2 : 2'd0;
                    if (phase_reg == 2'd1)
                    begin
                        held_reg <= in_byte;
                    end
                end
                else
                begin
                    held_reg  <= in_byte;
                    phase_reg <= 2'd1;
                end
            end
        end
    end

    // Key-adjusted code payload.
    always_ff @(posedge clk)
    begin
        if (accept && (phase_reg == 2'd1 || phase_reg == 2'd2))
        begin
            q_item_reg.code <= $signed({2'b00, raw_code})
                             - $signed({{6{key_byte[7]}}, key_byte});
        end
    end

endmodule

// ===== hw/rtl/lzwd_queue.sv =====
// Two-entry item queue between the front and back parts.
// Depends on lzwd_pkg.
module lzwd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_stall,
    input  lzwd_pkg::code_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_stall,
    output lzwd_pkg::code_item_t rd_item
);
    import lzwd_pkg::*;

    code_item_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign wr_stall = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && pop) |=> count_reg == 2'd1)
        else $error("queue count lost a pop");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 && push) |=> count_reg == 2'd1)
        else $error("queue count lost a push");

endmodule

// ===== hw/rtl/lzwd_back.sv =====
// Back part: LZW dictionary walk and string expansion.
// Depends on lzwd_pkg and lzwd_ram.
module lzwd_back #(
    parameter int DICT_ENTRIES = lzwd_pkg::DictEntriesDefault,
    parameter int MAX_STRING   = lzwd_pkg::MaxStringDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_stall,
    input  lzwd_pkg::code_item_t q_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 last_of_code,
    output logic [1:0]           status
);
    import lzwd_pkg::*;

    localparam int AW = $clog2(DICT_ENTRIES);
    localparam int LW = $clog2(MAX_STRING + 2);
    localparam int SW = $clog2(MAX_STRING + 1);
    localparam logic [LW-1:0] LenSat = LW'(MAX_STRING + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ERR   = 3'd4;
    localparam logic [2:0] S_LIT   = 3'd5;

    logic [2:0]     state_reg;
    logic [AW:0]    free_reg;
    logic [AW-1:0]  prev_reg;
    logic           first_reg;
    logic [AW-1:0]  cur_reg;
    logic [AW-1:0]  walk_reg;
    logic           kwkwk_reg;
    logic [LW-1:0]  len_reg;
    logic [SW-1:0]  pos_reg;
    logic [SW-1:0]  idx_reg;
    logic [7:0]     byte_reg;
    logic [1:0]     err_reg;
    logic           wait_rd_reg;
    logic [LW-1:0]  plen_reg;

    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    logic           out_last_reg;
    logic [1:0]     out_status_reg;

    logic [7:0]     stack_reg [MAX_STRING + 1];

    // Dictionary memories, written at most once per decoded code.
    logic           dict_we;
    logic [AW-1:0]  dict_waddr;
    logic [AW-1:0]  dict_raddr;
    logic [AW-1:0]  pre_rd;
    logic [7:0]     suf_rd;
    logic [LW-1:0]  len_rd;
    logic [AW-1:0]  rd_addr_lit;

    logic           out_free;
    logic           take;
    logic signed [13:0] code;
    logic           lit_rd;
    logic           last_go;
    logic           emit_go;
    logic           write_go;

    assign out_free  = !out_valid_reg || !out_stall;
    // A pending table write holds off the next code so its reads see the new entry.
    assign q_stall   = (state_reg != S_IDLE) || dict_we;
    assign take      = q_valid && !q_stall;
    assign code      = q_item.code;
    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_code = out_last_reg;
    assign status       = out_status_reg;

    // Result register load and table write conditions.
    assign last_go  = ((LW'(idx_reg) + LW'(1)) == len_reg);
    assign emit_go  = out_free && (state_reg == S_EMIT || state_reg == S_ERR
                                   || state_reg == S_LIT);
    assign write_go = out_free && (state_reg == S_EMIT) && last_go
                   && (free_reg < (AW+1)'(DICT_ENTRIES));

    // Literal entries are not stored: below 256 the tables read as literals.
    assign rd_addr_lit = dict_raddr;
    logic [AW-1:0] lit_addr_reg;
    always_ff @(posedge clk)
    begin
        lit_addr_reg <= rd_addr_lit;
    end
    assign lit_rd = (lit_addr_reg < AW'(256));

    logic [AW-1:0] pre_mem;
    logic [7:0]    suf_mem;
    logic [LW-1:0] len_mem;
    logic [AW-1:0] new_prefix;
    logic [7:0]    new_suffix;
    logic [LW-1:0] new_len;

    lzwd_ram #(.WIDTH(AW), .DEPTH(DICT_ENTRIES)) u_prefix (
        .clk(clk), .wr_en(dict_we), .wr_addr(dict_waddr), .wr_data(new_prefix),
        .rd_addr(dict_raddr), .rd_data(pre_mem));
    lzwd_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_suffix (
        .clk(clk), .wr_en(dict_we), .wr_addr(dict_waddr), .wr_data(new_suffix),
        .rd_addr(dict_raddr), .rd_data(suf_mem));
    lzwd_ram #(.WIDTH(LW), .DEPTH(DICT_ENTRIES)) u_length (
        .clk(clk), .wr_en(dict_we), .wr_addr(dict_waddr), .wr_data(new_len),
        .rd_addr(dict_raddr), .rd_data(len_mem));

    assign pre_rd = lit_rd ? '0 : pre_mem;
    assign suf_rd = lit_rd ? lit_addr_reg[7:0] : suf_mem;
    assign len_rd = lit_rd ? LW'(1) : len_mem;

    // Read address: the previous code while idle, else the current chain position.
    assign dict_raddr = (state_reg == S_IDLE) ? prev_reg : walk_reg;

    // Range check on an incoming code.
    logic in_range;
    assign in_range = (code >= 0) && (code < 14'(DICT_ENTRIES))
                   && ($unsigned(code) <= 14'(free_reg));

    // Sequencer: first literal, range or length error, else length lookup, chain walk, emit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= (AW+1)'(256);
            prev_reg      <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            dict_we       <= 1'b0;
            wait_rd_reg   <= 1'b0;
        end
        else
        begin
            dict_we <= write_go;
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        if (first_reg)
                        begin
                            if (code >= 0 && code <= 14'sd255)
                            begin
                                prev_reg  <= AW'($unsigned(code));
                                first_reg <= 1'b0;
                                byte_reg  <= code[7:0];
                                state_reg <= S_LIT;
                            end
                            else
                            begin
                                err_reg   <= STATUS_RANGE;
                                state_reg <= S_ERR;
                            end
                        end
                        else if (!in_range)
                        begin
                            err_reg   <= STATUS_RANGE;
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            cur_reg     <= AW'($unsigned(code));
                            kwkwk_reg   <= ($unsigned(code) == 14'(free_reg));
                            walk_reg    <= ($unsigned(code) == 14'(free_reg))
                                           ? prev_reg : AW'($unsigned(code));
                            wait_rd_reg <= 1'b1;
                            state_reg   <= S_LOOK;
                        end
                    end
                end
                S_LOOK:
                begin
                    // Wait for the registered read of the chain head.
                    if (wait_rd_reg)
                    begin
                        wait_rd_reg <= 1'b0;
                    end
                    else
                    begin
                        if (len_rd + LW'(kwkwk_reg) > LW'(MAX_STRING))
                        begin
                            err_reg   <= STATUS_TOO_LONG;
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            len_reg   <= len_rd + LW'(kwkwk_reg);
                            pos_reg   <= SW'(len_rd - LW'(1));
                            wait_rd_reg <= 1'b0;
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    // One stack byte per chain step: read, then store and follow.
                    if (!wait_rd_reg)
                    begin
                        stack_reg[pos_reg] <= suf_rd;
                        walk_reg <= pre_rd;
                        if (pos_reg == '0)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            pos_reg     <= pos_reg - SW'(1);
                            wait_rd_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        wait_rd_reg <= 1'b0;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= STATUS_OK;
                        out_last_reg   <= last_go;
                        out_byte_reg   <= (kwkwk_reg && last_go)
                                          ? stack_reg[0] : stack_reg[idx_reg];
                        if (last_go)
                        begin
                            if (free_reg < (AW+1)'(DICT_ENTRIES))
                            begin
                                dict_waddr <= free_reg[AW-1:0];
                                new_prefix <= prev_reg;
                                new_suffix <= stack_reg[0];
                                new_len    <= (plen_reg == LenSat) ? LenSat
                                                                   : plen_reg + LW'(1);
                                free_reg   <= free_reg + (AW+1)'(1);
                            end
                            prev_reg  <= cur_reg;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + SW'(1);
                        end
                    end
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= err_reg;
                        out_last_reg   <= 1'b1;
                        out_byte_reg   <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                S_LIT:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= STATUS_OK;
                        out_last_reg   <= 1'b1;
                        out_byte_reg   <= byte_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Length of the previous string, captured when it is read at code entry.
    logic idle_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_d_reg <= 1'b0;
        end
        else
        begin
            idle_d_reg <= take && !first_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (idle_d_reg)
        begin
            plen_reg <= len_rd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        dict_we |-> free_reg <= (AW+1)'(DICT_ENTRIES))
        else $error("dictionary written past its end");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_byte_reg))
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STATUS_OK) |-> out_last_reg)
        else $error("error result without last flag");

endmodule

// ===== test/lzw_decoder_12bit_keyed_top_tb.sv =====
// Self-checking testbench for the keyed 12-bit LZW decoder top level.
// Depends on lzwd_pkg and lzw_decoder_12bit_keyed_top; everything else is local.
`timescale 1ns / 1ps

module lzw_decoder_12bit_keyed_top_tb;

    import lzwd_pkg::*;

    localparam int DICT_SIZE  = 4096;
    localparam int STRING_MAX = 31;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 40;

    typedef struct {
        logic [7:0] text;
        logic       last;
        logic [1:0] stat;
    } text_item_t;

    // Scoreboard: a copy of the decoder state and the text items still owed.
    class lzw_text_scoreboard;
        logic [63:0] key_word[4];
        logic [5:0]  key_len_reg;
        int          prefix_of[DICT_SIZE];
        logic [7:0]  suffix_of[DICT_SIZE];
        int          length_of[DICT_SIZE];
        logic [7:0]  spell[STRING_MAX + 1];
        int          free_slot;
        int          prev_code;
        bit          awaiting_first;
        int          phase;
        logic [7:0]  held;
        int          key_pos;
        text_item_t  owed_text[$];
        int          mismatches;
        int          text_seen;
        int          error_seen;
        int          kwkwk_seen;

        function void init();
            for (int i = 0; i < 4; i++) key_word[i] = '0;
            key_len_reg = 6'd1;
            for (int i = 0; i < 256; i++)
            begin
                prefix_of[i] = 0;
                suffix_of[i] = i[7:0];
                length_of[i] = 1;
            end
            free_slot = 256;
            prev_code = 0;
            awaiting_first = 1;
            phase = 0;
            held = '0;
            key_pos = 0;
            mismatches = 0;
            text_seen = 0;
            error_seen = 0;
            kwkwk_seen = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] data);
            if (idx == CFG_KEY_LEN)
                key_len_reg = data[5:0];
            else if (idx <= CFG_KEY3)
                key_word[idx] = data;
        endfunction

        function int eff_len();
            if (key_len_reg == 0) return 1;
            if (key_len_reg > 32) return 32;
            return key_len_reg;
        endfunction

        // Signed key byte that the code ofs positions ahead will use.
        function int key_ahead(int ofs);
            int pos;
            logic [7:0] kb;
            pos = key_pos;
            for (int i = 0; i < ofs; i++)
            begin
                pos++;
                if (pos >= eff_len()) pos = 0;
            end
            kb = key_word[pos / 8][(pos % 8) * 8 +: 8];
            return $signed(kb);
        endfunction

        function int spell_out(int c);
            int n;
            int walk;
            n = length_of[c];
            walk = c;
            if (n > STRING_MAX) return n;
            for (int p = n - 1; p >= 0; p--)
            begin
                spell[p] = suffix_of[walk];
                walk = prefix_of[walk];
            end
            return n;
        endfunction

        function void owe(logic [7:0] t, logic l, logic [1:0] s);
            text_item_t it;
            it.text = t;
            it.last = l;
            it.stat = s;
            owed_text.push_back(it);
        endfunction

        function void decode(int code);
            int n;
            int nl;
            if (awaiting_first)
            begin
                if (code < 0 || code > 255)
                begin
                    owe(8'd0, 1'b1, STATUS_RANGE);
                    return;
                end
                prev_code = code;
                awaiting_first = 0;
                owe(code[7:0], 1'b1, STATUS_OK);
                return;
            end
            if (code < 0 || code >= DICT_SIZE || code > free_slot)
            begin
                owe(8'd0, 1'b1, STATUS_RANGE);
                return;
            end
            if (code < free_slot)
            begin
                n = spell_out(code);
                if (n > STRING_MAX)
                begin
                    owe(8'd0, 1'b1, STATUS_TOO_LONG);
                    return;
                end
            end
            else
            begin
                // Code not yet in the table: previous string plus its own first byte.
                n = spell_out(prev_code);
                if (n + 1 > STRING_MAX)
                begin
                    owe(8'd0, 1'b1, STATUS_TOO_LONG);
                    return;
                end
                spell[n] = spell[0];
                n++;
                kwkwk_seen++;
            end
            for (int i = 0; i < n; i++)
                owe(spell[i], i == n - 1, STATUS_OK);
            if (free_slot < DICT_SIZE)
            begin
                nl = length_of[prev_code] + 1;
                if (nl > STRING_MAX + 1) nl = STRING_MAX + 1;
                prefix_of[free_slot] = prev_code;
                suffix_of[free_slot] = spell[0];
                length_of[free_slot] = nl;
                free_slot++;
            end
            prev_code = code;
        endfunction

        // Notes one accepted input byte and appends the text it produces.
        function void note_byte(logic [7:0] b);
            int code;
            if (phase == 1)
            begin
                code = held * 16 + (b >> 4);
                held = b;
                phase = 2;
            end
            else if (phase == 2)
            begin
                code = b + (held & 8'h0f) * 256;
                phase = 0;
            end
            else
            begin
                held = b;
                phase = 1;
                return;
            end
            code -= key_ahead(0);
            key_pos++;
            if (key_pos >= eff_len()) key_pos = 0;
            decode(code);
        endfunction

        // Checks one accepted output item against the oldest owed one.
        function void check_text(logic [7:0] t, logic l, logic [1:0] s);
            text_item_t it;
            if (owed_text.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected item byte=%h last=%b status=%0d", t, l, s);
                return;
            end
            it = owed_text.pop_front();
            text_seen++;
            if (s != STATUS_OK) error_seen++;
            if (t !== it.text || l !== it.last || s !== it.stat)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: item %0d exp byte=%h last=%b status=%0d, got %h %b %0d",
                             text_seen, it.text, it.last, it.stat, t, l, s);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        last_of_code;
    logic [1:0]  status;

    lzw_text_scoreboard sb;
    bit   idle_on;
    bit   hold_armed;
    int   bytes_sent;
    int   idle_cycles;

    lzw_decoder_12bit_keyed_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_code (last_of_code),
        .status       (status)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog: too many cycles without any item moving ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("lzw_decoder_12bit_keyed_top regression: fail");
            $finish;
        end
    end

    // Output side: random stalls, one long hold-off, and checking.
    initial
    begin
        int w;
        out_stall = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            w = idle_on ? $urandom_range(0, 3) : 0;
            if (hold_armed)
            begin
                hold_armed = 0;
                w = 400;
            end
            if (w > 0)
            begin
                out_stall = 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_text(out_byte, last_of_code, status);
            @(negedge clk);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                             logic [63:0] k3, logic [5:0] len);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_KEY_LEN, {58'd0, len});
    endtask

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap) @(negedge clk);
        in_valid = 1'b1;
        in_byte = b;
        do @(posedge clk); while (in_stall);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Packs two intended codes, with the key added back, into three bytes.
    task automatic send_codes(int c1, int c2);
        int r1;
        int r2;
        r1 = c1 + sb.key_ahead(0);
        r2 = c2 + sb.key_ahead(1);
        r1 = (r1 < 0) ? 0 : (r1 > 4095) ? 4095 : r1;
        r2 = (r2 < 0) ? 0 : (r2 > 4095) ? 4095 : r2;
        send_byte(r1[11:4]);
        send_byte({r1[3:0], r2[11:8]});
        send_byte(r2[7:0]);
    endtask

    // Picks a code that decodes cleanly in most cases.
    function automatic int pick_code(bit first);
        int nf;
        int sel;
        nf = sb.free_slot;
        if (first) return $urandom_range(0, 255);
        sel = $urandom_range(0, 9);
        if (sel < 3) return $urandom_range(0, 255);
        if (sel < 6 && nf > 256) return $urandom_range(nf > 272 ? nf - 16 : 256, nf - 1);
        if (sel < 8 && nf < DICT_SIZE) return nf;
        return $urandom_range(0, nf < DICT_SIZE ? nf : DICT_SIZE - 1);
    endfunction

    task automatic random_codes(int n_bytes);
        int c1;
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: three arbitrary bytes, mostly range errors.
                repeat (3) send_byte($urandom_range(0, 255));
            end
            else
            begin
                c1 = pick_code(sb.awaiting_first);
                send_codes(c1, pick_code(sb.awaiting_first && (c1 < 0 || c1 > 255)));
            end
        end
    endtask

    // Repeated new-slot codes grow the string by one byte each until too long.
    task automatic grow_chain();
        send_codes($urandom_range(0, 255), sb.free_slot);
        repeat (17) send_codes(sb.free_slot, sb.free_slot + 1);
    endtask

    task automatic drain();
        while (sb.owed_text.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        sb.init();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_KEY0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_byte = '0;
        idle_on = 1;
        hold_armed = 0;
        bytes_sent = 0;
        idle_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero key, first-code errors, literal extremes, new-slot code,
        // out-of-range codes.
        write_key(64'd0, 64'd0, 64'd0, 64'd0, 6'd1);
        send_codes(4095, 256);
        send_codes(0, 255);
        send_codes(257, 4095);
        send_codes(256, 259);
        send_codes(258, 0);
        send_codes(255, 3000);
        send_codes(1, 1);
        send_codes(262, 263);
        drain();

        // Mixed key, short cycle.
        write_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, 6'd5);
        random_codes(72);
        drain();

        // All-ones key at full length; the receiver holds off for a while.
        write_key('1, '1, '1, '1, 6'd32);
        idle_on = 0;
        random_codes(24);
        hold_armed = 1;
        idle_on = 1;
        random_codes(48);
        drain();

        // Most negative and most positive key bytes, out-of-range lengths.
        write_key(64'h7f80_7f80_7f80_7f80, 64'h807f_807f_807f_807f, '0, '1, 6'd0);
        grow_chain();
        drain();
        write_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, 6'd63);
        grow_chain();
        random_codes(54);
        drain();

        $display("Run covered %0d input bytes, %0d output items, %0d error items,",
                 bytes_sent, sb.text_seen, sb.error_seen);
        $display("%0d new-slot codes, several key settings and a long output hold-off.",
                 sb.kwkwk_seen);
        if (sb.mismatches == 0 && sb.owed_text.size() == 0)
            $display("lzw_decoder_12bit_keyed_top regression: pass");
        else
            $display("lzw_decoder_12bit_keyed_top regression: fail");
        $finish;
    end

endmodule
